@@ design/mmn_pkg.sv @@
`default_nettype none

package mmn_pkg;

  // Result is unsigned Q1.16, 0 .. 1.0
  localparam int unsigned ScaledW  = 17;
  localparam logic [ScaledW-1:0] OneQ16  = 17'h10000;
  localparam logic [ScaledW-1:0] ZeroQ16 = 17'h00000;

  // Output beat: scaled, clipped, zero fill to whole bytes
  localparam int unsigned OutDataW = ((ScaledW + 1 + 7) / 8) * 8;

  // Divider runs one quotient bit per cycle
  localparam int unsigned QuotBits = ScaledW;
  localparam int unsigned StepCntW = $clog2(QuotBits);

  // Input tuser bit positions
  localparam int unsigned UserKindBit  = 0;
  localparam int unsigned UserFirstBit = 1;
  localparam int unsigned UserW        = 2;

  // Sample kinds
  localparam logic KindMeasure = 1'b0;
  localparam logic KindScale   = 1'b1;

  // Queue between classifier and divider
  localparam int unsigned QDepth = 2;

  // What the back end does with a queued scale item
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,  // nothing measured or flat range
    RES_LOW  = 2'd1,  // below min, saturate to 0
    RES_HIGH = 2'd2,  // above max, saturate to 1.0
    RES_DIV  = 2'd3   // in range, divide
  } res_code_e;

  localparam int unsigned CodeW = 2;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ design/mmn_front.sv @@
`default_nettype none

module mmn_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic                         kind_i,
  input  wire logic                         first_i,
  input  wire logic [SAMPLE_BITS-1:0]       sample_i,
  input  wire mmn_pkg::q_stat_t             q_stat_i,
  output logic                              push_o,
  output mmn_pkg::res_code_e                code_o,
  output logic [SAMPLE_BITS-1:0]            off_o,
  output logic [SAMPLE_BITS-1:0]            span_o
);
  import mmn_pkg::*;

  logic signed [SAMPLE_BITS-1:0] low_q, low_d;
  logic signed [SAMPLE_BITS-1:0] high_q, high_d;
  logic                          have_q, have_d;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS:0]   off_wide;
  logic signed [SAMPLE_BITS:0]   span_wide;
  logic                          take;

  assign x        = $signed(sample_i);
  assign ready_o  = ~q_stat_i.full;
  assign take     = valid_i & ready_o;
  assign push_o   = take & (kind_i == KindScale);

  assign off_wide  = {x[SAMPLE_BITS-1], x} - {low_q[SAMPLE_BITS-1], low_q};
  assign span_wide = {high_q[SAMPLE_BITS-1], high_q} - {low_q[SAMPLE_BITS-1], low_q};
  assign off_o     = off_wide[SAMPLE_BITS-1:0];
  assign span_o    = span_wide[SAMPLE_BITS-1:0];

  // Classify a scale sample against the current range
  always_comb begin
    priority if (!have_q || !(high_q > low_q)) begin
      code_o = RES_ZERO;
    end else if (x < low_q) begin
      code_o = RES_LOW;
    end else if (x > high_q) begin
      code_o = RES_HIGH;
    end else begin
      code_o = RES_DIV;
    end
  end

  // Track min and max over measure samples
  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    have_d = have_q;
    if (take && kind_i == KindMeasure) begin
      if (first_i || !have_q) begin
        low_d  = x;
        high_d = x;
        have_d = 1'b1;
      end else begin
        if (x > high_q) high_d = x;
        if (x < low_q)  low_d  = x;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
      have_q <= 1'b0;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
      have_q <= have_d;
    end
  end

endmodule

`default_nettype wire

@@ design/mmn_queue.sv @@
`default_nettype none

module mmn_queue #(
  parameter int unsigned WIDTH = 34
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output mmn_pkg::q_stat_t      stat_o
);
  import mmn_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic [WIDTH-1:0] mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_pop;

  assign stat_o.full  = (cnt_q == CntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];
  assign do_pop       = pop_i & ~stat_o.empty;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      unique case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

endmodule

`default_nettype wire

@@ design/mmn_back.sv @@
`default_nettype none

module mmn_back #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mmn_pkg::q_stat_t           q_stat_i,
  input  wire mmn_pkg::res_code_e         code_i,
  input  wire logic [SAMPLE_BITS-1:0]     off_i,
  input  wire logic [SAMPLE_BITS-1:0]     span_i,
  output logic                            pop_o,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output logic [mmn_pkg::ScaledW-1:0]     scaled_o,
  output logic                            clipped_o
);
  import mmn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [StepCntW-1:0]    cnt_q;
  logic [SAMPLE_BITS:0]   rem_q;
  logic [SAMPLE_BITS-1:0] span_q;
  logic [ScaledW-1:0]     quo_q;
  logic                   clip_q;

  logic                   ge;
  logic [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]   rem_sub;

  // One restoring step: compare, subtract, shift
  assign diff    = rem_q - {1'b0, span_q};
  assign ge      = (rem_q >= {1'b0, span_q});
  assign rem_sub = ge ? diff : rem_q;

  assign pop_o = (state_q == ST_IDLE) & ~q_stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rem_q     <= '0;
      span_q    <= '0;
      quo_q     <= '0;
      clip_q    <= 1'b0;
      valid_o   <= 1'b0;
      scaled_o  <= '0;
      clipped_o <= 1'b0;
    end else begin
      if (valid_o && ready_i) valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!q_stat_i.empty) begin
            unique case (code_i)
              RES_ZERO: begin
                quo_q   <= ZeroQ16;
                clip_q  <= 1'b0;
                state_q <= ST_DONE;
              end
              RES_LOW: begin
                quo_q   <= ZeroQ16;
                clip_q  <= 1'b1;
                state_q <= ST_DONE;
              end
              RES_HIGH: begin
                quo_q   <= OneQ16;
                clip_q  <= 1'b1;
                state_q <= ST_DONE;
              end
              RES_DIV: begin
                rem_q   <= {1'b0, off_i};
                span_q  <= span_i;
                quo_q   <= '0;
                clip_q  <= 1'b0;
                cnt_q   <= '0;
                state_q <= ST_RUN;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_RUN: begin
          rem_q <= {rem_sub[SAMPLE_BITS-1:0], 1'b0};
          quo_q <= {quo_q[ScaledW-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == StepCntW'(QuotBits - 1)) state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hand over once the output register is free
          if (!valid_o || ready_i) begin
            valid_o   <= 1'b1;
            scaled_o  <= quo_q;
            clipped_o <= clip_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_scaled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> scaled_o <= OneQ16)
    else $error("scaled above 1.0");

  a_clip_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && clipped_o) |-> (scaled_o == ZeroQ16 || scaled_o == OneQ16))
    else $error("clipped result not saturated");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (span_q != '0 && rem_q <= {span_q, 1'b0}))
    else $error("divider remainder out of bound");

endmodule

`default_nettype wire

@@ design/min_max_normalizer_core.sv @@
// Min-max normalizer: measure beats track min/max, scale beats give (x-min)/(max-min) Q1.16.
// Scale beat in range: queued, then 17 divider steps, then held until the output register is free.
// Saturated or flat-range scale beat: queued, then handed to the output without division. Measure beats give no output.
// The one-bit-per-cycle divider takes one in-range scale beat at a time; the two-entry queue holds
// further scale beats meanwhile. Measure beats go at one per cycle while the queue has room.
// Reset (rst_ni low, asynchronous): min, max and the measured flag clear, queue and output empty.
`default_nettype none

module min_max_normalizer_core #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Input stream
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // [SAMPLE_BITS-1:0] sample, zero fill above
  input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  // [0] kind (0 measure, 1 scale), [1] first
  input  wire logic [mmn_pkg::UserW-1:0]              s_axis_tuser,
  // Output stream
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // [16:0] scaled (Q1.16), [17] clipped, zero fill above
  output logic [mmn_pkg::OutDataW-1:0]                m_axis_tdata
);
  import mmn_pkg::*;

  localparam int unsigned EntryW = CodeW + 2 * SAMPLE_BITS;

  q_stat_t                q_stat;
  logic                   push;
  logic                   pop;
  res_code_e              code_in;
  logic [SAMPLE_BITS-1:0] off_in, span_in;
  logic [EntryW-1:0]      q_wdata, q_rdata;
  logic [ScaledW-1:0]     scaled;
  logic                   clipped;

  // Front: accept beats, update min/max, classify scale beats
  mmn_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .kind_i   (s_axis_tuser[UserKindBit]),
    .first_i  (s_axis_tuser[UserFirstBit]),
    .sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .q_stat_i (q_stat),
    .push_o   (push),
    .code_o   (code_in),
    .off_o    (off_in),
    .span_o   (span_in)
  );

  // Each entry carries the range snapshot taken when the beat was accepted
  assign q_wdata = {code_in, off_in, span_in};

  mmn_queue #(
    .WIDTH (EntryW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  // Back: saturate or run the iterative divider, hold the result beat
  mmn_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .code_i    (res_code_e'(q_rdata[EntryW-1 -: CodeW])),
    .off_i     (q_rdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS]),
    .span_i    (q_rdata[SAMPLE_BITS-1:0]),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .scaled_o  (scaled),
    .clipped_o (clipped)
  );

  assign m_axis_tdata = {{(OutDataW - ScaledW - 1){1'b0}}, clipped, scaled};

endmodule

`default_nettype wire
